@@ design/ipr_pkg.sv @@
// ipr_pkg: shared types and constants for the image packet reassembler
// no dependencies; used by every module in design/

package ipr_pkg;

    localparam int unsigned PACKET_BYTES_DEF = 223;
    localparam int unsigned BYTE_W           = 8;
    localparam int unsigned WORD_W           = 16;
    localparam int unsigned INDEX_W          = 4;
    localparam int unsigned ID_W             = 12;

    localparam logic [WORD_W-1:0] MARKER_RESET = 16'hAAAA;

    // header layout of each packet kind
    localparam logic [BYTE_W-1:0] MARKED_LEN_POS      = 8'd37;
    localparam logic [BYTE_W-1:0] MARKED_IDX_POS      = 8'd39;
    localparam logic [BYTE_W-1:0] MARKED_PAYLOAD_POS  = 8'd40;
    localparam logic [BYTE_W-1:0] UNMARKED_LEN_POS    = 8'd1;
    localparam logic [BYTE_W-1:0] UNMARKED_IDX_POS    = 8'd3;
    localparam logic [BYTE_W-1:0] UNMARKED_PAYLOAD_POS = 8'd4;
    localparam logic [BYTE_W-1:0] CONT_IDX_POS        = 8'd1;
    localparam logic [BYTE_W-1:0] CONT_PAYLOAD_POS    = 8'd2;
    localparam logic [BYTE_W-1:0] KIND_DECIDE_POS     = 8'd1;

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_MARKED   = 2'd1,
        KIND_UNMARKED = 2'd2,
        KIND_CONT     = 2'd3
    } kind_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              dropped;
    } result_t;

endpackage

@@ design/ipr_parser.sv @@
// ipr_parser: input register, packet header tracking and payload selection
// depends on ipr_pkg; feeds ipr_out_reg

module ipr_parser #(
    parameter int unsigned PACKET_BYTES = ipr_pkg::PACKET_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ipr_pkg::BYTE_W-1:0] s_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ipr_pkg::WORD_W-1:0] cfg_data,
    input  logic                       res_ready,
    output ipr_pkg::result_t           res
);
    import ipr_pkg::*;

    logic                in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic [WORD_W-1:0]   marker_reg;
    logic [BYTE_W-1:0]   pos_reg, pos_next;
    kind_t               kind_reg, kind_next;
    logic [WORD_W-1:0]   hold_reg, hold_next;
    logic [WORD_W-1:0]   rem_reg, rem_next;
    logic                expect_reg, expect_next;
    logic [INDEX_W-1:0]  index_reg, index_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic                drop_reg, drop_next;

    logic                fire;
    logic [BYTE_W-1:0]   first_payload;
    logic [INDEX_W-1:0]  rx_index;
    logic [ID_W-1:0]     rx_id;
    logic [BYTE_W:0]     pos_inc;
    logic                drop_now;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && res_ready;
    assign s_tready  = !in_valid_reg || res_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        pos_next      = pos_reg;
        kind_next     = kind_reg;
        hold_next     = hold_reg;
        rem_next      = rem_reg;
        expect_next   = expect_reg;
        index_next    = index_reg;
        id_next       = id_reg;
        drop_next     = drop_reg;
        first_payload = '0;
        drop_now      = 1'b0;
        res           = '0;
        rx_index      = '0;
        rx_id         = '0;
        pos_inc       = {1'b0, pos_reg} + {{BYTE_W{1'b0}}, 1'b1};

        if (fire && !drop_reg)
        begin
            hold_next = {hold_reg[BYTE_W-1:0], in_byte_reg};
            rx_index  = hold_next[WORD_W-1 -: INDEX_W];
            rx_id     = hold_next[ID_W-1:0];

            if (pos_reg == KIND_DECIDE_POS)
            begin
                if (hold_next == marker_reg)
                begin
                    kind_next = KIND_MARKED;
                end
                else if (expect_reg)
                begin
                    kind_next = KIND_CONT;
                end
                else
                begin
                    kind_next = KIND_UNMARKED;
                end
            end

            case (kind_next)
                KIND_MARKED:
                begin
                    first_payload = MARKED_PAYLOAD_POS;
                    if (pos_reg == MARKED_LEN_POS)
                    begin
                        rem_next = hold_next;
                    end
                    if (pos_reg == MARKED_IDX_POS)
                    begin
                        index_next = rx_index;
                        id_next    = rx_id;
                    end
                end
                KIND_UNMARKED:
                begin
                    first_payload = UNMARKED_PAYLOAD_POS;
                    if (pos_reg == UNMARKED_LEN_POS)
                    begin
                        rem_next = hold_next;
                    end
                    if (pos_reg == UNMARKED_IDX_POS)
                    begin
                        index_next = rx_index;
                        id_next    = rx_id;
                    end
                end
                KIND_CONT:
                begin
                    first_payload = CONT_PAYLOAD_POS;
                    if (pos_reg == CONT_IDX_POS)
                    begin
                        // no wrap: index fifteen never has a successor
                        if (({1'b0, rx_index} != {1'b0, index_reg} + 5'd1)
                            || (rx_id != id_reg))
                        begin
                            drop_now = 1'b1;
                        end
                        else
                        begin
                            index_next = rx_index;
                        end
                    end
                end
                default:
                begin
                    first_payload = '0;
                end
            endcase

            if (drop_now)
            begin
                drop_next   = 1'b1;
                res.valid   = 1'b1;
                res.dropped = 1'b1;
            end
            else
            begin
                if ((kind_next != KIND_NONE) && (pos_reg >= first_payload)
                    && (rem_next != '0))
                begin
                    rem_next  = rem_next - {{(WORD_W-1){1'b0}}, 1'b1};
                    res.valid = 1'b1;
                    res.data  = in_byte_reg;
                    res.last  = (rem_next == '0);
                end
                if (pos_inc >= (BYTE_W+1)'(PACKET_BYTES))
                begin
                    pos_next    = '0;
                    kind_next   = KIND_NONE;
                    expect_next = (rem_next != '0);
                end
                else
                begin
                    pos_next = pos_inc[BYTE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            marker_reg   <= MARKER_RESET;
            pos_reg      <= '0;
            kind_reg     <= KIND_NONE;
            hold_reg     <= '0;
            rem_reg      <= '0;
            expect_reg   <= 1'b0;
            index_reg    <= '0;
            id_reg       <= '0;
            drop_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                marker_reg <= cfg_data;
            end
            pos_reg    <= pos_next;
            kind_reg   <= kind_next;
            hold_reg   <= hold_next;
            rem_reg    <= rem_next;
            expect_reg <= expect_next;
            index_reg  <= index_next;
            id_reg     <= id_next;
            drop_reg   <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    a_silent_after_drop: assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg |-> !res.valid)
        else $error("result produced after drop");

    a_drop_at_header: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.dropped) |-> (pos_reg == CONT_IDX_POS) && expect_reg)
        else $error("drop outside continuation header");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, pos_reg} < (BYTE_W+1)'(PACKET_BYTES))
        else $error("byte position out of packet");

    a_kind_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == '0) |-> (kind_reg == KIND_NONE))
        else $error("packet kind left over at packet start");

endmodule

@@ design/ipr_out_reg.sv @@
// ipr_out_reg: result register toward the output stream
// depends on ipr_pkg; driven by ipr_parser

module ipr_out_reg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ipr_pkg::result_t           res,
    output logic                       res_ready,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [ipr_pkg::BYTE_W-1:0] m_tdata,
    output logic                       m_tlast,
    output logic                       m_tuser
);
    import ipr_pkg::*;

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              last_reg;
    logic              dropped_reg;

    assign res_ready = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_ready)
        begin
            valid_next = res.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            data_reg    <= res.data;
            last_reg    <= res.last;
            dropped_reg <= res.dropped;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = dropped_reg;

    a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (!m_tlast && (m_tdata == '0)))
        else $error("drop result carries payload");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> res_ready == 1'b0)
        else $error("result register overwritten while stalled");

    a_no_result_after_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tuser) |=> !res.valid)
        else $error("result after drop transfer");

endmodule

@@ design/image_packet_reassembler_top.sv @@
// image packet reassembler: one packet byte per transfer in, payload bytes out
// path: a taken byte is held in the parser's input register, then its result in the output register that drives m_*
// throughput: one byte per cycle unless m_tready stalls the output, set by the per-byte header/length update
// reset: rst_n clears all packet state, marker returns to 16'hAAAA
// depends on ipr_pkg, ipr_parser, ipr_out_reg

module image_packet_reassembler_top #(
    parameter int unsigned PACKET_BYTES = ipr_pkg::PACKET_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ipr_pkg::BYTE_W-1:0] s_tdata,   // in_byte
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [ipr_pkg::BYTE_W-1:0] m_tdata,   // payload_byte
    output logic                       m_tlast,   // last_of_image
    output logic                       m_tuser,   // dropped
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ipr_pkg::WORD_W-1:0] cfg_data   // start_marker
);
    import ipr_pkg::*;

    result_t res;
    logic    res_ready;

    ipr_parser #(
        .PACKET_BYTES(PACKET_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .res_ready (res_ready),
        .res       (res)
    );

    ipr_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
